// File: rtl/core/pos_pkg.sv
package pos_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int FILL_W  = 7;
  localparam int STAT_W  = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_POP
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic place;
    logic pop;
    logic rej_full;
    logic rej_empty;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic p_zero;
    logic greater;
  } stat_t;

endpackage

// File: rtl/core/pos_ctrl.sv
module pos_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_op,
  input  pos_pkg::stat_t stat,
  output pos_pkg::cmd_t  cmd,
  output logic          busy
);
  import pos_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (op_t'(in_op) == OP_POP) begin
            if (stat.empty) begin
              cmd.rej_empty = 1'b1;
            end else begin
              state_nxt = S_POP;
            end
          end else begin
            if (stat.full) begin
              cmd.rej_full = 1'b1;
            end else begin
              state_nxt = S_INSERT;
            end
          end
        end
      end
      S_INSERT: begin
        if (!stat.p_zero && stat.greater) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/core/pos_datapath.sv
module pos_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pos_pkg::cmd_t                 cmd,
  input  logic signed [31:0]            in_value,
  input  logic signed [31:0]            in_priority_req,
  output pos_pkg::stat_t                stat,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic signed [31:0]            out_value,
  output logic signed [31:0]            out_priority,
  output logic [6:0]                    out_fill_count
);
  import pos_pkg::*;

  logic [2*DATA_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W-1:0]        p_r;
  logic [CNT_W-1:0]        p_nxt;
  logic [IDX_W-1:0]        rd_addr;
  logic [2*DATA_W-1:0]     rd_data_r;
  logic signed [DATA_W-1:0] new_value_r;
  logic signed [DATA_W-1:0] new_prio_r;
  logic signed [DATA_W-1:0] rd_prio;

  logic                    valid_r;
  status_t                 status_r;
  logic [DATA_W-1:0]       value_r;
  logic [DATA_W-1:0]       prio_r;
  logic [FILL_W-1:0]       fill_r;

  assign rd_prio = rd_data_r[DATA_W-1:0];

  always_comb begin
    priority if (cmd.load) begin
      p_nxt = count_r;
    end else if (cmd.shift) begin
      p_nxt = p_r - CNT_W'(1);
    end else begin
      p_nxt = p_r;
    end
  end

  assign rd_addr = IDX_W'(p_nxt - CNT_W'(1));

  always_comb begin
    priority if (cmd.place) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  assign stat.full    = (count_r == CNT_W'(DEPTH));
  assign stat.empty   = (count_r == '0);
  assign stat.p_zero  = (p_r == '0);
  assign stat.greater = (rd_prio > new_prio_r);

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (cmd.shift) begin
      mem[IDX_W'(p_r)] <= rd_data_r;
    end else if (cmd.place) begin
      mem[IDX_W'(p_r)] <= {new_value_r, new_prio_r};
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (cmd.load) begin
      new_value_r <= in_value;
      new_prio_r  <= in_priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= cmd.place | cmd.pop | cmd.rej_full | cmd.rej_empty;
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= FILL_W'(count_nxt);
    priority if (cmd.pop) begin
      status_r <= ST_OK;
      value_r  <= rd_data_r[2*DATA_W-1:DATA_W];
      prio_r   <= rd_data_r[DATA_W-1:0];
    end else if (cmd.rej_full) begin
      status_r <= ST_FULL;
      value_r  <= '0;
      prio_r   <= '0;
    end else if (cmd.rej_empty) begin
      status_r <= ST_EMPTY;
      value_r  <= '0;
      prio_r   <= '0;
    end else begin
      status_r <= ST_OK;
      value_r  <= '0;
      prio_r   <= '0;
    end
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_value      = value_r;
  assign out_priority   = prio_r;
  assign out_fill_count = fill_r;

endmodule

// File: rtl/core/priority_ordered_stack_core.sv
// Priority queue of 64 (value, priority) entries kept sorted in one memory,
// highest priority on top; among equal priorities the newest leaves first.
// A command transfers at a rising edge with start high and busy low, and its
// result appears on the out_ ports the cycle after the command completes,
// marked by out_valid for exactly one cycle; there is no back-pressure, so
// the receiver must take every result as it appears. A pop goes through S_POP.
// An insert stays in S_INSERT while the entry below its slot has strictly
// greater priority: those entries move up one memory slot per cycle through
// the single write port. A rejected insert (store full) or a pop of an empty
// store is answered from S_IDLE and leaves the store unchanged.
module priority_ordered_stack_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_priority_req,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_priority,
  output logic [6:0]         out_fill_count
);
  import pos_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pos_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pos_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_value        (in_value),
    .in_priority_req (in_priority_req),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_priority    (out_priority),
    .out_fill_count  (out_fill_count)
  );

endmodule
